// ===== rtl/core/bba_pkg.sv =====
// Package: shared constants and types for the buddy block allocator.
package bba_pkg;

    localparam int MIN_ORDER_DEF    = 5;
    localparam int MAX_ORDER_DEF    = 16;
    localparam int HEADER_BYTES_DEF = 32;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_A_PREP,
        ST_A_SCAN,
        ST_A_SPLIT,
        ST_A_DONE,
        ST_F_CHECK,
        ST_F_RDORD,
        ST_F_WAIT,
        ST_F_UP,
        ST_F_MERGE,
        ST_F_SET,
        ST_RESP
    } bba_state_t;

    typedef struct packed {
        logic init_start;
        logic init_step;
        logic a_prep;
        logic a_scan;
        logic a_split;
        logic a_done;
        logic f_check;
        logic f_rdord;
        logic f_load;
        logic f_up;
        logic f_merge;
        logic f_set;
        logic resp;
    } bba_cmd_t;

    typedef struct packed {
        logic init_last;
        logic a_nospace;
        logic a_hit;
        logic a_scan_end;
        logic a_split_last;
        logic f_bad;
        logic f_up_fail;
        logic f_up_last;
        logic f_merge_stop;
    } bba_stat_t;

endpackage

// ===== rtl/core/bba_ram.sv =====
// Generic single-port RAM with registered read.
module bba_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== rtl/core/bba_ctrl.sv =====
// Controller state machine for the buddy allocator.
module bba_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              action,
    input  logic              cfg_write,
    input  bba_pkg::bba_stat_t stat,
    output bba_pkg::bba_cmd_t  cmd,
    output logic              busy
);
    bba_pkg::bba_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bba_pkg::ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bba_pkg::ST_IDLE:
            begin
                if (cfg_write)
                begin
                    state_next = bba_pkg::ST_INIT;
                end
                else if (start)
                begin
                    state_next = action ? bba_pkg::ST_F_CHECK : bba_pkg::ST_A_PREP;
                end
            end
            bba_pkg::ST_INIT:
            begin
                if (stat.init_last)
                begin
                    state_next = bba_pkg::ST_IDLE;
                end
            end
            bba_pkg::ST_A_PREP:
            begin
                state_next = stat.a_nospace ? bba_pkg::ST_RESP : bba_pkg::ST_A_SCAN;
            end
            bba_pkg::ST_A_SCAN:
            begin
                if (stat.a_hit)
                begin
                    state_next = stat.a_split_last ? bba_pkg::ST_A_DONE : bba_pkg::ST_A_SPLIT;
                end
                else if (stat.a_scan_end)
                begin
                    state_next = bba_pkg::ST_RESP;
                end
            end
            bba_pkg::ST_A_SPLIT:
            begin
                if (stat.a_split_last)
                begin
                    state_next = bba_pkg::ST_A_DONE;
                end
            end
            bba_pkg::ST_A_DONE:   state_next = bba_pkg::ST_RESP;
            bba_pkg::ST_F_CHECK:
            begin
                state_next = stat.f_bad ? bba_pkg::ST_RESP : bba_pkg::ST_F_RDORD;
            end
            bba_pkg::ST_F_RDORD:  state_next = bba_pkg::ST_F_WAIT;
            bba_pkg::ST_F_WAIT:
            begin
                state_next = stat.f_bad ? bba_pkg::ST_RESP : bba_pkg::ST_F_UP;
            end
            bba_pkg::ST_F_UP:
            begin
                if (stat.f_up_fail)
                begin
                    state_next = bba_pkg::ST_RESP;
                end
                else if (stat.f_up_last)
                begin
                    state_next = bba_pkg::ST_F_MERGE;
                end
            end
            bba_pkg::ST_F_MERGE:
            begin
                if (stat.f_merge_stop)
                begin
                    state_next = bba_pkg::ST_F_SET;
                end
            end
            bba_pkg::ST_F_SET:    state_next = bba_pkg::ST_RESP;
            bba_pkg::ST_RESP:     state_next = bba_pkg::ST_IDLE;
            default:              state_next = bba_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        busy = (state_reg != bba_pkg::ST_IDLE);
        unique case (state_reg)
            bba_pkg::ST_IDLE:    cmd.init_start = cfg_write;
            bba_pkg::ST_INIT:    cmd.init_step = 1'b1;
            bba_pkg::ST_A_PREP:  cmd.a_prep = 1'b1;
            bba_pkg::ST_A_SCAN:  cmd.a_scan = 1'b1;
            bba_pkg::ST_A_SPLIT: cmd.a_split = 1'b1;
            bba_pkg::ST_A_DONE:  cmd.a_done = 1'b1;
            bba_pkg::ST_F_CHECK: cmd.f_check = 1'b1;
            bba_pkg::ST_F_RDORD: cmd.f_rdord = 1'b1;
            bba_pkg::ST_F_WAIT:  cmd.f_load = 1'b1;
            bba_pkg::ST_F_UP:    cmd.f_up = 1'b1;
            bba_pkg::ST_F_MERGE: cmd.f_merge = 1'b1;
            bba_pkg::ST_F_SET:   cmd.f_set = 1'b1;
            bba_pkg::ST_RESP:    cmd.resp = 1'b1;
            default:             cmd = '0;
        endcase
    end
endmodule

// ===== rtl/core/bba_datapath.sv =====
// Datapath: free bitmaps, order table, search, split and merge logic.
module bba_datapath #(
    parameter int MIN_ORDER    = bba_pkg::MIN_ORDER_DEF,
    parameter int MAX_ORDER    = bba_pkg::MAX_ORDER_DEF,
    parameter int HEADER_BYTES = bba_pkg::HEADER_BYTES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  bba_pkg::bba_cmd_t  cmd,
    input  logic [4:0]         cfg_data,
    input  logic               start_acc,
    input  logic [15:0]        request_bytes_in,
    input  logic [15:0]        block_offset_in,
    output bba_pkg::bba_stat_t stat,
    output logic               done,
    output logic [15:0]        granted_offset,
    output logic               status
);
    localparam int TOP    = (MAX_ORDER < 16) ? MAX_ORDER : 16;
    localparam int LVLS   = TOP - MIN_ORDER + 1;
    localparam int TSIZE  = (1 << LVLS) - 1;
    localparam int SLOTS  = 1 << (TOP - MIN_ORDER);
    localparam int TW     = $clog2(TSIZE + 1);
    localparam int SW     = (TOP - MIN_ORDER) > 0 ? (TOP - MIN_ORDER) : 1;
    localparam int OW     = 5;

    // One free bit per tree node (2^(TOP-MIN_ORDER+1)-1 nodes, 4095 at the
    // default sizes), held in a bit RAM with a registered read.
    logic [TW-1:0] t_addr;
    logic          t_we, t_wd, t_rd;
    bba_ram #(.WIDTH(1), .DEPTH(TSIZE)) u_tree (
        .clk(clk), .we(t_we), .addr(t_addr), .wdata(t_wd), .rdata(t_rd)
    );

    logic [SW-1:0] o_addr;
    logic          o_we;
    logic [3:0]    o_wd, o_rd;
    bba_ram #(.WIDTH(4), .DEPTH(SLOTS)) u_ord (
        .clk(clk), .we(o_we), .addr(o_addr), .wdata(o_wd), .rdata(o_rd)
    );

    logic [OW-1:0] heap_reg, want_reg, k_reg;
    logic [16:0]   off_reg;
    logic [16:0]   scan_reg;
    logic          rd_pend_reg;
    logic [TW-1:0] init_reg;
    logic [15:0]   g_off_reg;
    logic          g_st_reg, done_reg;
    logic [4:0]    cfg_clamp;

    function automatic logic [TW-1:0] tidx(input logic [OW-1:0] k, input logic [16:0] off);
        logic [16:0] base;
        logic [16:0] i;
        begin
            base = (17'd1 << (5'(TOP) - k)) - 17'd1;
            i = base + (off >> k);
            tidx = (i < 17'(TSIZE)) ? TW'(i) : '0;
        end
    endfunction

    assign cfg_clamp = (cfg_data < 5'(MIN_ORDER)) ? 5'(MIN_ORDER) :
                       (cfg_data > 5'(TOP)) ? 5'(TOP) : cfg_data;

    logic [15:0] req_lat_reg, foff_lat_reg;

    // rounded order of request plus header
    logic [16:0] need;
    logic [4:0]  want_c;
    always_comb
    begin
        need = 17'(req_lat_reg) + 17'(HEADER_BYTES);
        want_c = 5'(MIN_ORDER);
        for (int w = 16; w >= MIN_ORDER; w--)
        begin
            if ((17'd1 << w) >= need)
            begin
                want_c = 5'(w);
            end
        end
        if (need > 17'h10000)
        begin
            want_c = 5'd17;
        end
    end

    logic [16:0] heap_end;
    logic [16:0] step_k;
    logic [16:0] half_k;
    assign heap_end = 17'd1 << heap_reg;
    assign step_k   = 17'd1 << k_reg;
    assign half_k   = 17'd1 << (k_reg - 5'd1);

    // alloc: scan_reg holds address of node being read; rd_pend marks valid data
    logic [16:0] scan_nxt_off;
    logic [OW-1:0] scan_nxt_k;
    always_comb
    begin
        if (scan_reg + step_k >= heap_end)
        begin
            scan_nxt_off = '0;
            scan_nxt_k = k_reg + 5'd1;
        end
        else
        begin
            scan_nxt_off = scan_reg + step_k;
            scan_nxt_k = k_reg;
        end
    end

    logic [16:0] buddy;
    assign buddy = off_reg ^ step_k;

    logic [16:0] foff_in;
    assign foff_in = {1'b0, foff_lat_reg};

    always_comb
    begin
        stat = '0;
        stat.init_last    = (init_reg == TW'(TSIZE - 1));
        stat.a_nospace    = (want_c > heap_reg);
        stat.a_hit        = rd_pend_reg && t_rd;
        stat.a_scan_end   = rd_pend_reg && !t_rd && (k_reg == heap_reg) &&
                            (scan_reg + step_k >= heap_end);
        stat.a_split_last = cmd.a_scan ? (k_reg == want_reg) : (k_reg - 5'd1 == want_reg);
        stat.f_bad        = cmd.f_check ?
                            ((foff_in >= heap_end) ||
                             (foff_in[MIN_ORDER-1:0] != '0)) :
                            ((5'(o_rd) + 5'(MIN_ORDER) > heap_reg) ||
                             ((foff_in & ((17'd1 << (5'(o_rd) + 5'(MIN_ORDER))) - 17'd1)) != '0));
        stat.f_up_fail    = rd_pend_reg && t_rd;
        stat.f_up_last    = rd_pend_reg && !t_rd && (k_reg == heap_reg);
        stat.f_merge_stop = (k_reg == heap_reg) || (rd_pend_reg && !t_rd);
    end

    // RAM port steering
    always_comb
    begin
        t_we = 1'b0;
        t_wd = 1'b0;
        t_addr = tidx(k_reg, scan_reg);
        o_we = 1'b0;
        o_wd = 4'(want_reg - 5'(MIN_ORDER));
        o_addr = SW'(off_reg >> MIN_ORDER);
        if (cmd.init_step)
        begin
            t_we = 1'b1;
            t_addr = init_reg;
            t_wd = (init_reg == tidx(heap_reg, 17'd0));
        end
        else if (cmd.a_scan)
        begin
            // a hit clears the node just read
            if (stat.a_hit)
            begin
                t_we = 1'b1;
                t_wd = 1'b0;
            end
            t_addr = tidx(k_reg, scan_reg);
        end
        else if (cmd.a_split)
        begin
            t_we = 1'b1;
            t_wd = 1'b1;
            t_addr = tidx(k_reg - 5'd1, off_reg + half_k);
        end
        else if (cmd.a_done)
        begin
            o_we = 1'b1;
        end
        else if (cmd.f_rdord)
        begin
            o_addr = SW'(foff_in >> MIN_ORDER);
        end
        else if (cmd.f_up)
        begin
            t_addr = tidx(k_reg, scan_reg);
        end
        else if (cmd.f_merge)
        begin
            if (rd_pend_reg && t_rd)
            begin
                t_we = 1'b1;
                t_wd = 1'b0;
                t_addr = tidx(k_reg, buddy);
            end
            else
            begin
                t_addr = tidx(k_reg, buddy);
            end
        end
        else if (cmd.f_set)
        begin
            t_we = 1'b1;
            t_wd = 1'b1;
            t_addr = tidx(k_reg, off_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_reg <= 5'(TOP);
            init_reg <= '0;
            done_reg <= 1'b0;
            rd_pend_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.resp;
            if (cmd.init_start)
            begin
                heap_reg <= cfg_clamp;
                init_reg <= '0;
            end
            else if (cmd.init_step)
            begin
                init_reg <= init_reg + TW'(1);
            end
            if (cmd.a_prep || cmd.f_load)
            begin
                rd_pend_reg <= 1'b0;
            end
            else if (cmd.a_scan)
            begin
                rd_pend_reg <= !rd_pend_reg && !stat.a_hit;
            end
            else if (cmd.f_up)
            begin
                rd_pend_reg <= !rd_pend_reg || t_rd;
            end
            else if (cmd.f_merge)
            begin
                // a merge step restarts the read one level up
                rd_pend_reg <= !rd_pend_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start_acc)
        begin
            req_lat_reg <= request_bytes_in;
            foff_lat_reg <= block_offset_in;
            g_off_reg <= '0;
            g_st_reg <= 1'b0;
        end
        if (cmd.a_prep)
        begin
            want_reg <= want_c;
            k_reg <= want_c;
            scan_reg <= '0;
            g_st_reg <= (want_c > heap_reg);
        end
        if (cmd.a_scan && rd_pend_reg)
        begin
            if (t_rd)
            begin
                off_reg <= scan_reg;
            end
            else
            begin
                scan_reg <= scan_nxt_off;
                k_reg <= scan_nxt_k;
                if (stat.a_scan_end)
                begin
                    g_st_reg <= 1'b1;
                end
            end
        end
        if (cmd.a_split)
        begin
            k_reg <= k_reg - 5'd1;
        end
        if (cmd.a_done)
        begin
            g_off_reg <= off_reg[15:0];
        end
        if (cmd.f_load)
        begin
            k_reg <= 5'(o_rd) + 5'(MIN_ORDER);
            off_reg <= foff_in;
            scan_reg <= foff_in;
        end
        if (cmd.f_up && rd_pend_reg && !t_rd && (k_reg != heap_reg))
        begin
            k_reg <= k_reg + 5'd1;
            scan_reg <= foff_in & ~((17'd1 << (k_reg + 5'd1)) - 17'd1);
        end
        if (cmd.f_up && stat.f_up_last)
        begin
            k_reg <= 5'(o_rd) + 5'(MIN_ORDER);
        end
        if (cmd.f_merge && rd_pend_reg && t_rd)
        begin
            off_reg <= off_reg & ~step_k;
            k_reg <= k_reg + 5'd1;
        end
    end

    assign done = done_reg;
    assign granted_offset = g_off_reg;
    assign status = g_st_reg;
endmodule

// ===== rtl/core/buddy_block_allocator.sv =====
// Top level of the binary buddy block allocator.
//
// Usage:
//   Command channel: drive action, request_bytes and block_offset and raise
//   start; the word is taken at a clock edge where start is high and busy is
//   low. One result word per command appears on granted_offset and status for
//   exactly one cycle, marked by done; the receiver cannot stall it.
//   Allocate (action 0) rounds request plus header up to a power of two and
//   returns the lowest-offset block of the smallest fitting free order.
//   Free (action 1) returns the block and merges it with free buddies.
//   Config channel: cfg_valid/cfg_ready write heap_order (ready only when idle
//   and start is low); the write clears the free bitmap and restarts the heap.
// Flow: one node of the free bitmap RAM is read at a time and checked before
//   the next read. An allocate scans nodes, splits the block it finds and
//   records its order; a free checks its offset, reads the order table, checks
//   the levels above and merges with free buddies; a rejected free goes to the
//   response. One command at a time; the next may be taken in the done cycle.
// Reset: the bitmap RAM is swept one node per cycle over every node of the tree
//   with busy high; only the whole heap starts free.
module buddy_block_allocator #(
    parameter int MIN_ORDER    = bba_pkg::MIN_ORDER_DEF,
    parameter int MAX_ORDER    = bba_pkg::MAX_ORDER_DEF,
    parameter int HEADER_BYTES = bba_pkg::HEADER_BYTES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        action,
    input  logic [15:0] request_bytes,
    input  logic [15:0] block_offset,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data,
    output logic        done,
    output logic [15:0] granted_offset,
    output logic        status
);
    bba_pkg::bba_cmd_t  cmd;
    bba_pkg::bba_stat_t stat;
    logic               cfg_write;

    // a command has priority over config in the same idle cycle
    assign cfg_ready = !busy && !start;
    assign cfg_write = cfg_valid && cfg_ready;

    bba_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .action(action),
        .cfg_write(cfg_write), .stat(stat), .cmd(cmd), .busy(busy)
    );

    bba_datapath #(
        .MIN_ORDER(MIN_ORDER), .MAX_ORDER(MAX_ORDER), .HEADER_BYTES(HEADER_BYTES)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .cfg_data(cfg_data),
        .start_acc(start && !busy),
        .request_bytes_in(request_bytes), .block_offset_in(block_offset),
        .stat(stat), .done(done), .granted_offset(granted_offset), .status(status)
    );
endmodule

// ===== rtl/core/bba_checker.sv =====
// Port-level checker for the buddy block allocator, bound to the top level.
module bba_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        cfg_ready,
    input logic        done,
    input logic [15:0] granted_offset,
    input logic        status
);
    a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted command did not raise busy");
    a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");
    a_nospace_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status) |-> (granted_offset == 16'd0))
        else $error("no-space result carries an offset");
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> (!busy && !start))
        else $error("config ready while busy or a command is offered");
endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .cfg_ready(cfg_ready), .done(done), .granted_offset(granted_offset),
    .status(status)
);

// ===== tb/buddy_block_allocator_tb.sv =====
// Testbench for the buddy block allocator: directed and random commands checked against a predictor.
module buddy_block_allocator_tb;

    localparam int MIN_ORD  = bba_pkg::MIN_ORDER_DEF;
    localparam int TOP_ORD  = bba_pkg::MAX_ORDER_DEF < 16 ? bba_pkg::MAX_ORDER_DEF : 16;
    localparam int HDR      = bba_pkg::HEADER_BYTES_DEF;
    localparam int NODES    = (1 << (TOP_ORD - MIN_ORD + 1)) - 1;
    localparam int SLOTS    = 1 << (TOP_ORD - MIN_ORD);

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;
    localparam logic ST_OK      = 1'b0;
    localparam logic ST_NOSPACE = 1'b1;

    // one command word plus the result it must produce
    typedef struct {
        logic        act;
        logic [15:0] req;
        logic [15:0] off;
        logic [15:0] want_off;
        logic        want_st;
    } cmd_t;

    typedef struct {
        logic [15:0] off;
        logic        st;
    } grant_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        action = 1'b0;
    logic [15:0] request_bytes = '0;
    logic [15:0] block_offset = '0;
    logic        cfg_valid = 1'b0;
    logic [4:0]  cfg_data = '0;
    logic        busy, cfg_ready, done, status;
    logic [15:0] granted_offset;

    cmd_t   cmd_q[$];      // commands waiting for the driver
    grant_t grant_q[$];    // results owed by the block, oldest first
    cmd_t   cur_cmd;
    int     err_cnt = 0;

    buddy_block_allocator dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .action         (action),
        .request_bytes  (request_bytes),
        .block_offset   (block_offset),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .done           (done),
        .granted_offset (granted_offset),
        .status         (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_err(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    // ---------------------------------------------------------------
    // Allocator shadow: free bit per node of the order tree, plus the
    // order code recorded per minimum block at grant time.
    // ---------------------------------------------------------------
    int unsigned heap_ord;
    bit          free_map[NODES];
    bit [3:0]    order_tab[SLOTS];

    function automatic int unsigned node_idx(int unsigned k, int unsigned off);
        int unsigned i;
        i = ((1 << (TOP_ORD - k)) - 1) + (off >> k);
        return (i < NODES) ? i : 0;
    endfunction

    function automatic void heap_restart(int unsigned v);
        heap_ord = v < MIN_ORD ? MIN_ORD : (v > TOP_ORD ? TOP_ORD : v);
        foreach (free_map[i]) free_map[i] = 1'b0;
        free_map[node_idx(heap_ord, 0)] = 1'b1;
    endfunction

    // smallest fitting order, lowest offset first; split down leaving upper halves free
    function automatic grant_t grant_block(int unsigned req);
        grant_t      g;
        int unsigned need, want, k, off;
        g.off = '0;
        g.st  = ST_NOSPACE;
        need = req + HDR;
        want = MIN_ORD;
        while (want < 31 && (1 << want) < need) want++;
        if (want > heap_ord) return g;
        for (k = want; k <= heap_ord; k++) begin
            for (off = 0; off < (1 << heap_ord); off += (1 << k)) begin
                if (free_map[node_idx(k, off)]) begin
                    free_map[node_idx(k, off)] = 1'b0;
                    while (k > want) begin
                        k--;
                        free_map[node_idx(k, off + (1 << k))] = 1'b1;
                    end
                    order_tab[(off >> MIN_ORD) % SLOTS] = 4'((want - MIN_ORD) & 15);
                    g.off = off[15:0];
                    g.st  = ST_OK;
                    return g;
                end
            end
        end
        return g;
    endfunction

    // release a block and coalesce with free buddies of equal order
    function automatic void release_block(int unsigned off);
        int unsigned k, j, bud;
        if (off >= (1 << heap_ord)) return;
        if ((off & ((1 << MIN_ORD) - 1)) != 0) return;
        k = order_tab[(off >> MIN_ORD) % SLOTS] + MIN_ORD;
        if (k > heap_ord) return;
        if ((off & ((1 << k) - 1)) != 0) return;
        for (j = k; j <= heap_ord; j++)
            if (free_map[node_idx(j, off & ~((1 << j) - 1))]) return;
        while (k < heap_ord) begin
            bud = off ^ (1 << k);
            if (!free_map[node_idx(k, bud)]) break;
            free_map[node_idx(k, bud)] = 1'b0;
            off &= ~(1 << k);
            k++;
        end
        free_map[node_idx(k, off)] = 1'b1;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus bookkeeping. live_blocks holds offsets granted in the
    // current heap setting; granted_hist holds every offset ever
    // granted, so a free never touches an order entry left unwritten.
    // ---------------------------------------------------------------
    logic [15:0] live_blocks[$];
    logic [15:0] granted_hist[$];

    task automatic queue_cmd(logic act, logic [15:0] req, logic [15:0] off);
        cmd_t   c;
        grant_t g;
        c.act = act;
        c.req = req;
        c.off = off;
        g.off = '0;
        g.st  = ST_OK;
        if (act == ACT_ALLOC) begin
            g = grant_block(req);
            if (g.st == ST_OK) begin
                live_blocks  = {live_blocks, g.off};
                granted_hist = {granted_hist, g.off};
            end
        end else begin
            release_block(off);
        end
        c.want_off = g.off;
        c.want_st  = g.st;
        cmd_q = {cmd_q, c};
    endtask

    // request sized to land on a random order around the current heap
    function automatic logic [15:0] pick_request();
        int unsigned o, lo, hi;
        if ($urandom_range(0, 9) == 0) return 16'($urandom);
        o  = $urandom_range(MIN_ORD, heap_ord + 1);
        hi = (1 << o) - HDR;
        lo = (o == MIN_ORD) ? 0 : (1 << (o - 1)) - HDR + 1;
        if (hi > 65535) hi = 65535;
        if (lo > hi) lo = hi;
        return 16'($urandom_range(lo, hi));
    endfunction

    // an offset the block has to reject before looking up its order
    function automatic logic [15:0] pick_bad_offset();
        logic [15:0] v;
        v = 16'($urandom);
        if (heap_ord < 16 && $urandom_range(0, 1))
            return 16'($urandom_range(1 << heap_ord, 65535));
        v[4:0] = 5'($urandom_range(1, 31));
        return v;
    endfunction

    task automatic random_cmd();
        int unsigned r, i;
        logic [15:0] o;
        r = $urandom_range(0, 99);
        if (r < 50 || (r < 85 && live_blocks.size() == 0)) begin
            queue_cmd(ACT_ALLOC, pick_request(), 16'($urandom));
        end else if (r < 85) begin
            i = $urandom_range(0, live_blocks.size() - 1);
            o = live_blocks[i];
            live_blocks.delete(i);
            queue_cmd(ACT_FREE, 16'($urandom), o);
        end else if (r < 92 && granted_hist.size() > 0) begin
            // stale or repeated free of an offset granted at some point
            o = granted_hist[$urandom_range(0, granted_hist.size() - 1)];
            queue_cmd(ACT_FREE, 16'($urandom), o);
        end else begin
            queue_cmd(ACT_FREE, 16'($urandom), pick_bad_offset());
        end
    endtask

    task automatic wait_drained();
        do @(posedge clk);
        while (cmd_q.size() != 0 || start || grant_q.size() != 0);
    endtask

    // heap_order write; only issued with the block drained
    task automatic write_heap_order(logic [4:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        heap_restart(v);
        live_blocks.delete();
    endtask

    // ---------------------------------------------------------------
    // Driver: holds start until accepted, then draws an idle gap
    // ---------------------------------------------------------------
    int  gap_left = 0;
    bit  burst = 1'b0;

    always @(posedge clk)
    begin
        if (rst_n && ((start && !busy) || !start)) begin
            if (start) begin
                grant_q = {grant_q, grant_t'{off: cur_cmd.want_off, st: cur_cmd.want_st}};
                if ($urandom_range(0, 39) == 0) burst = !burst;
                gap_left = burst ? 0 : $urandom_range(0, 16);
            end
            if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (cmd_q.size() > 0) begin
                cur_cmd = cmd_q.pop_front();
                action        <= cur_cmd.act;
                request_bytes <= cur_cmd.req;
                block_offset  <= cur_cmd.off;
                start         <= 1'b1;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: every done cycle carries one result word
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        grant_t g;
        if (rst_n && done) begin
            if (grant_q.size() == 0) begin
                report_err($sformatf("unexpected result off=%h st=%0b",
                                     granted_offset, status));
            end else begin
                g = grant_q.pop_front();
                if (granted_offset !== g.off)
                    report_err($sformatf("granted_offset %h, expected %h",
                                         granted_offset, g.off));
                if (status !== g.st)
                    report_err($sformatf("status %0b, expected %0b", status, g.st));
            end
        end
    end

    // ---------------------------------------------------------------
    // Sequence: directed checks at the reset heap size, then phases
    // at several heap sizes, including clamped settings 0 and 31.
    // ---------------------------------------------------------------
    logic [4:0] phase_ord[16] = '{5'd0, 5'd31, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10,
                                  5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16, 5'd7, 5'd9};

    initial
    begin
        int n;
        foreach (order_tab[i]) order_tab[i] = '0;
        heap_restart(16);
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // whole heap, then full heap, then back
        queue_cmd(ACT_ALLOC, 16'd65504, 16'hFFFF);
        queue_cmd(ACT_ALLOC, 16'd0, 16'h0000);
        queue_cmd(ACT_FREE, 16'hFFFF, 16'd0);
        // oversized requests
        queue_cmd(ACT_ALLOC, 16'hFFFF, 16'd0);
        queue_cmd(ACT_ALLOC, 16'd65505, 16'd0);
        // a few small grants with splitting
        queue_cmd(ACT_ALLOC, 16'd0, 16'd0);
        queue_cmd(ACT_ALLOC, 16'd1, 16'd0);
        queue_cmd(ACT_ALLOC, 16'd0, 16'd0);
        queue_cmd(ACT_ALLOC, 16'd4000, 16'd0);
        // double free and misaligned offsets
        queue_cmd(ACT_FREE, 16'd0, 16'd32);
        queue_cmd(ACT_FREE, 16'd0, 16'd32);
        queue_cmd(ACT_FREE, 16'd0, 16'd33);
        queue_cmd(ACT_FREE, 16'd0, 16'hFFFF);
        // merges back up to the whole heap
        queue_cmd(ACT_FREE, 16'd0, 16'd64);
        queue_cmd(ACT_FREE, 16'd0, 16'd0);
        queue_cmd(ACT_FREE, 16'd0, 16'd4096);
        queue_cmd(ACT_ALLOC, 16'd65504, 16'd0);
        queue_cmd(ACT_FREE, 16'd0, 16'd0);
        live_blocks.delete();
        wait_drained();

        foreach (phase_ord[p]) begin
            write_heap_order(phase_ord[p]);
            n = heap_ord <= 10 ? 60 : (heap_ord <= 13 ? 30 : 15);
            // bad offsets past the heap end only exist below the top order
            if (heap_ord < 16) queue_cmd(ACT_FREE, 16'd0, 16'(1 << heap_ord));
            repeat (n) random_cmd();
            wait_drained();
        end

        repeat (100) @(posedge clk);
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // watchdog
    initial
    begin
        #400_000_000;
        $display("TIMEOUT");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/bba_pkg.sv
rtl/core/bba_ram.sv
rtl/core/bba_ctrl.sv
rtl/core/bba_datapath.sv
rtl/core/buddy_block_allocator.sv
rtl/core/bba_checker.sv
tb/buddy_block_allocator_tb.sv
